### rtl/double_ended_queue_defines.svh
// assertion macros for the double ended queue
// no dependencies; clocked on clk_i, disabled while rst_ni is low
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DEQ_ASSERT_SAME(lbl, ante, cons, msg)
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/deq_pkg.sv
// shared types and codes for the double ended queue
// no dependencies
package deq_pkg;

  localparam int DepthDefault = 16;
  localparam int KindW        = 3;
  localparam int ValueW       = 32;
  localparam int StatusW      = 2;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH_REAR  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_LIST       = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LIST = 1'b1
  } state_e;

endpackage

### rtl/deq_if.sv
// handshake channels of the double ended queue: operation in, result out
// depends on deq_pkg
interface deq_in_if;
  logic                                valid;
  logic                                ready;
  logic        [deq_pkg::KindW-1:0]    kind;
  logic signed [deq_pkg::ValueW-1:0]   value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_out_if;
  logic                                valid;
  logic                                ready;
  logic        [deq_pkg::StatusW-1:0]  status;
  logic signed [deq_pkg::ValueW-1:0]   value_res;
  logic                                last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

### rtl/double_ended_queue.sv
// double ended queue: ring buffer in one synchronous memory, read data registered
// push and pop: one transaction per cycle while the output is taken, result valid in the cycle after acceptance
// list: count words, one word per cycle while the output is taken
// the single memory port pair (one write, one registered read) sets these figures
// reset (rst_ni low, asynchronous) empties the queue; memory contents are not cleared
// depends on deq_pkg, deq_if and double_ended_queue_defines.svh
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  deq_in_if.sink    in_i,
  deq_out_if.source out_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);

  function automatic logic [IdxW-1:0] idx_inc(input logic [IdxW-1:0] i);
    idx_inc = (i == LastIdx) ? '0 : i + IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] idx_dec(input logic [IdxW-1:0] i);
    idx_dec = (i == '0) ? LastIdx : i - IdxW'(1);
  endfunction

  logic signed [deq_pkg::ValueW-1:0] mem_q [DEPTH];
  logic signed [deq_pkg::ValueW-1:0] rdata_q;

  deq_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]  front_q, front_d, rear_q, rear_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  list_idx_q, list_idx_d;
  logic [CntW-1:0]  list_left_q, list_left_d;

  logic                             out_valid_q, out_valid_d;
  logic [deq_pkg::StatusW-1:0]      status_q, status_d;
  logic                             last_q, last_d;
  logic                             from_mem_q, from_mem_d;

  logic             in_ready, accept, out_free, full, empty;
  logic             wr_en, rd_en;
  logic [IdxW-1:0]  wr_addr, rd_addr;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q == deq_pkg::ST_IDLE) && out_free;
  assign accept   = in_i.valid && in_ready;
  assign full     = (count_q == DepthCnt);
  assign empty    = (count_q == '0);

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.last      = last_q;
  assign out_o.value_res = from_mem_q ? rdata_q : '0;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    count_d     = count_q;
    list_idx_d  = list_idx_q;
    list_left_d = list_left_q;
    out_valid_d = out_valid_q && !out_o.ready;
    status_d    = status_q;
    last_d      = last_q;
    from_mem_d  = from_mem_q;
    wr_en       = 1'b0;
    wr_addr     = rear_q;
    rd_en       = 1'b0;
    rd_addr     = front_q;

    case (state_q)
      deq_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_i.kind)
            deq_pkg::KIND_PUSH_REAR, deq_pkg::KIND_PUSH_FRONT: begin
              out_valid_d = 1'b1;
              last_d      = 1'b1;
              from_mem_d  = 1'b0;
              if (full) begin
                status_d = deq_pkg::STATUS_FULL;
              end else begin
                status_d = deq_pkg::STATUS_OK;
                wr_en    = 1'b1;
                count_d  = count_q + CntW'(1);
                if (in_i.kind == deq_pkg::KIND_PUSH_REAR) begin
                  wr_addr = rear_q;
                  rear_d  = idx_inc(rear_q);
                end else begin
                  wr_addr = idx_dec(front_q);
                  front_d = idx_dec(front_q);
                end
              end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR, deq_pkg::KIND_LIST: begin
              out_valid_d = 1'b1;
              last_d      = 1'b1;
              if (empty) begin
                status_d   = deq_pkg::STATUS_EMPTY;
                from_mem_d = 1'b0;
              end else begin
                status_d   = deq_pkg::STATUS_OK;
                from_mem_d = 1'b1;
                rd_en      = 1'b1;
                if (in_i.kind == deq_pkg::KIND_POP_FRONT) begin
                  rd_addr = front_q;
                  front_d = idx_inc(front_q);
                  count_d = count_q - CntW'(1);
                end else if (in_i.kind == deq_pkg::KIND_POP_REAR) begin
                  rd_addr = idx_dec(rear_q);
                  rear_d  = idx_dec(rear_q);
                  count_d = count_q - CntW'(1);
                end else begin
                  // list: first word now, the rest walked in ST_LIST
                  rd_addr     = front_q;
                  last_d      = (count_q == CntW'(1));
                  list_idx_d  = idx_inc(front_q);
                  list_left_d = count_q - CntW'(1);
                  if (count_q != CntW'(1)) begin
                    state_d = deq_pkg::ST_LIST;
                  end
                end
              end
            end
            default: begin
              // unused codes are taken and dropped
            end
          endcase
        end
      end
      deq_pkg::ST_LIST: begin
        if (out_free) begin
          rd_en       = 1'b1;
          rd_addr     = list_idx_q;
          out_valid_d = 1'b1;
          status_d    = deq_pkg::STATUS_OK;
          from_mem_d  = 1'b1;
          last_d      = (list_left_q == CntW'(1));
          list_idx_d  = idx_inc(list_idx_q);
          list_left_d = list_left_q - CntW'(1);
          if (list_left_q == CntW'(1)) begin
            state_d = deq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = deq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      count_q     <= '0;
      list_idx_q  <= '0;
      list_left_q <= '0;
      out_valid_q <= 1'b0;
      status_q    <= deq_pkg::STATUS_OK;
      last_q      <= 1'b0;
      from_mem_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      count_q     <= count_d;
      list_idx_q  <= list_idx_d;
      list_left_q <= list_left_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      last_q      <= last_d;
      from_mem_q  <= from_mem_d;
    end
  end

  // read data register doubles as the output word and holds while stalled
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= in_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  `DEQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= DepthCnt, "fill count above depth")
  `DEQ_ASSERT_SAME(a_empty_idx, count_q == '0, front_q == rear_q, "empty queue, indices apart")
  `DEQ_ASSERT_SAME(a_no_read_stall, out_valid_q && !out_o.ready, !rd_en, "read over held word")
  `DEQ_ASSERT_SAME(a_list_busy, state_q == deq_pkg::ST_LIST, !in_ready && !wr_en,
                   "transaction taken during list")
  `DEQ_ASSERT_NEXT(a_push_count, accept && !full && (in_i.kind == deq_pkg::KIND_PUSH_REAR ||
                   in_i.kind == deq_pkg::KIND_PUSH_FRONT), count_q == $past(count_q) + CntW'(1),
                   "push did not grow the queue")

endmodule

### tb/sv/testbench.sv
// self-checking testbench for double_ended_queue: random and directed operations
// with idling on both channels, results checked against an in-bench deque model
// depends on deq_pkg, deq_if and the double_ended_queue rtl
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH      = deq_pkg::DepthDefault;
  localparam int RandomOps  = 110;
  localparam int IdlePct    = 29;
  localparam int CalmFrom   = 120;
  localparam int CalmTo     = 260;
  localparam int StallLimit = 1000;
  localparam int DrainCycles = 2 * DEPTH + 4;

  // codes outside the defined operations, dropped by the block
  localparam logic [deq_pkg::KindW-1:0] KindSpareLo = 3'd5;
  localparam logic [deq_pkg::KindW-1:0] KindSpareHi = 3'd7;

  typedef struct {
    logic [deq_pkg::KindW-1:0]         kind;
    logic signed [deq_pkg::ValueW-1:0] value;
  } deq_op_t;

  typedef struct {
    deq_pkg::status_e                  status;
    logic signed [deq_pkg::ValueW-1:0] word;
    logic                              last;
  } deq_result_t;

  logic clk_i;
  logic rst_ni;

  deq_in_if  op_ch ();
  deq_out_if res_ch ();

  double_ended_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_ch),
    .out_o (res_ch)
  );

  deq_op_t     op_backlog[$];
  deq_result_t awaited_results[$];

  // deque model state
  logic signed [deq_pkg::ValueW-1:0] slots[DEPTH];
  int unsigned                       head_slot;
  int unsigned                       tail_slot;
  int unsigned                       fill_level;

  int  ops_queued;
  int  ops_accepted;
  int  cycle_count;
  int  quiet_cycles;
  bit  op_taken;
  bit  mismatch_seen;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic void expect_result(deq_pkg::status_e status,
                                        logic signed [deq_pkg::ValueW-1:0] word,
                                        logic last);
    deq_result_t r;
    r.status = status;
    r.word   = word;
    r.last   = last;
    awaited_results.push_back(r);
  endfunction

  function automatic void apply_deque_op(logic [deq_pkg::KindW-1:0] kind,
                                         logic signed [deq_pkg::ValueW-1:0] word);
    int unsigned idx;
    case (kind)
      deq_pkg::KIND_PUSH_REAR, deq_pkg::KIND_PUSH_FRONT: begin
        if (fill_level >= DEPTH) begin
          expect_result(deq_pkg::STATUS_FULL, '0, 1'b1);
        end else begin
          if (kind == deq_pkg::KIND_PUSH_REAR) begin
            slots[tail_slot] = word;
            tail_slot = (tail_slot + 1) % DEPTH;
          end else begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            slots[head_slot] = word;
          end
          fill_level++;
          expect_result(deq_pkg::STATUS_OK, '0, 1'b1);
        end
      end
      deq_pkg::KIND_POP_FRONT: begin
        if (fill_level == 0) begin
          expect_result(deq_pkg::STATUS_EMPTY, '0, 1'b1);
        end else begin
          expect_result(deq_pkg::STATUS_OK, slots[head_slot], 1'b1);
          head_slot = (head_slot + 1) % DEPTH;
          fill_level--;
        end
      end
      deq_pkg::KIND_POP_REAR: begin
        if (fill_level == 0) begin
          expect_result(deq_pkg::STATUS_EMPTY, '0, 1'b1);
        end else begin
          tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
          expect_result(deq_pkg::STATUS_OK, slots[tail_slot], 1'b1);
          fill_level--;
        end
      end
      deq_pkg::KIND_LIST: begin
        if (fill_level == 0) begin
          expect_result(deq_pkg::STATUS_EMPTY, '0, 1'b1);
        end else begin
          idx = head_slot;
          for (int unsigned n = 0; n < fill_level; n++) begin
            expect_result(deq_pkg::STATUS_OK, slots[idx], (n + 1 == fill_level));
            idx = (idx + 1) % DEPTH;
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [deq_pkg::ValueW-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(deq_pkg::ValueW-1){1'b1}}};
      1: return {1'b1, {(deq_pkg::ValueW-1){1'b0}}};
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // returns 1 when the operation is one the block acts on
  function automatic int queue_op(logic [deq_pkg::KindW-1:0] kind,
                                  logic signed [deq_pkg::ValueW-1:0] value);
    deq_op_t op;
    op.kind  = kind;
    op.value = value;
    op_backlog.push_back(op);
    ops_queued++;
    return (kind <= deq_pkg::KIND_LIST) ? 1 : 0;
  endfunction

  // driver: inputs move on the falling edge only
  always @(negedge clk_i) begin
    deq_op_t next_op;
    bit      calm;
    if (rst_ni) begin
      calm = (cycle_count >= CalmFrom) && (cycle_count < CalmTo);
      if (!op_ch.valid || op_taken) begin
        if (op_backlog.size() > 0 && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          next_op = op_backlog.pop_front();
          op_ch.valid <= 1'b1;
          op_ch.kind  <= next_op.kind;
          op_ch.value <= next_op.value;
        end else begin
          op_ch.valid <= 1'b0;
        end
      end
      res_ch.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  // monitor: samples both channels on the rising edge
  always @(posedge clk_i) begin
    deq_result_t exp_res;
    bit          any_fire;
    if (rst_ni) begin
      cycle_count++;
      op_taken <= op_ch.valid && op_ch.ready;
      any_fire = 1'b0;
      if (op_ch.valid && op_ch.ready) begin
        apply_deque_op(op_ch.kind, op_ch.value);
        ops_accepted++;
        any_fire = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        any_fire = 1'b1;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, got status %0d value %0d last %0b", $time,
                   res_ch.status, res_ch.value_res, res_ch.last);
          mismatch_seen = 1'b1;
        end else begin
          exp_res = awaited_results.pop_front();
          if (res_ch.status !== exp_res.status) begin
            $display("%0t: status expected %0d, got %0d", $time, exp_res.status,
                     res_ch.status);
            mismatch_seen = 1'b1;
          end
          if (res_ch.value_res !== exp_res.word) begin
            $display("%0t: value_res expected %0d, got %0d", $time, exp_res.word,
                     res_ch.value_res);
            mismatch_seen = 1'b1;
          end
          if (res_ch.last !== exp_res.last) begin
            $display("%0t: last expected %0b, got %0b", $time, exp_res.last, res_ch.last);
            mismatch_seen = 1'b1;
          end
        end
      end
      quiet_cycles = any_fire ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int counted;
    int burst;
    int pick;
    logic [deq_pkg::KindW-1:0] k;

    rst_ni        = 1'b0;
    op_ch.valid   = 1'b0;
    op_ch.kind    = deq_pkg::KIND_PUSH_REAR;
    op_ch.value   = '0;
    res_ch.ready  = 1'b0;
    op_taken      = 1'b0;
    mismatch_seen = 1'b0;
    ops_queued    = 0;
    ops_accepted  = 0;
    cycle_count   = 0;
    quiet_cycles  = 0;
    head_slot     = 0;
    tail_slot     = 0;
    fill_level    = 0;
    counted       = 0;

    // empty deque: both pops and list answer empty
    counted += queue_op(deq_pkg::KIND_POP_FRONT, '0);
    counted += queue_op(deq_pkg::KIND_POP_REAR, '0);
    counted += queue_op(deq_pkg::KIND_LIST, '0);
    // front push on empty must also set the rear
    counted += queue_op(deq_pkg::KIND_PUSH_FRONT, {1'b1, {(deq_pkg::ValueW-1){1'b0}}});
    counted += queue_op(deq_pkg::KIND_POP_REAR, '0);
    counted += queue_op(deq_pkg::KIND_POP_FRONT, '0);
    // rear pop of a single word empties the deque fully
    counted += queue_op(deq_pkg::KIND_PUSH_REAR, {1'b0, {(deq_pkg::ValueW-1){1'b1}}});
    counted += queue_op(deq_pkg::KIND_POP_REAR, '0);
    counted += queue_op(deq_pkg::KIND_POP_FRONT, '0);
    counted += queue_op(deq_pkg::KIND_LIST, '0);
    counted += queue_op(deq_pkg::KIND_PUSH_REAR, '0);
    counted += queue_op(deq_pkg::KIND_PUSH_FRONT, '1);
    counted += queue_op(deq_pkg::KIND_LIST, '0);
    for (logic [deq_pkg::KindW:0] s = {1'b0, KindSpareLo}; s <= {1'b0, KindSpareHi}; s++) begin
      counted += queue_op(s[deq_pkg::KindW-1:0], '1);
    end
    counted += queue_op(deq_pkg::KIND_POP_FRONT, '0);
    counted += queue_op(deq_pkg::KIND_POP_FRONT, '0);

    // fill past full, list the whole store, then drain past empty
    for (int i = 0; i < DEPTH + 1; i++) begin
      counted += queue_op(($urandom_range(0, 1) != 0) ? deq_pkg::KIND_PUSH_FRONT
                                                      : deq_pkg::KIND_PUSH_REAR,
                          pick_word());
    end
    counted += queue_op(deq_pkg::KIND_LIST, '0);
    for (int i = 0; i < DEPTH + 1; i++) begin
      counted += queue_op(($urandom_range(0, 1) != 0) ? deq_pkg::KIND_POP_FRONT
                                                      : deq_pkg::KIND_POP_REAR, '0);
    end

    while (counted < RandomOps) begin
      pick  = $urandom_range(0, 9);
      burst = $urandom_range(3, DEPTH + 2);
      if (pick < 3) begin
        for (int i = 0; i < burst; i++) begin
          counted += queue_op(($urandom_range(0, 1) != 0) ? deq_pkg::KIND_PUSH_FRONT
                                                          : deq_pkg::KIND_PUSH_REAR,
                              pick_word());
        end
      end else if (pick < 5) begin
        for (int i = 0; i < burst; i++) begin
          counted += queue_op(($urandom_range(0, 1) != 0) ? deq_pkg::KIND_POP_FRONT
                                                          : deq_pkg::KIND_POP_REAR,
                              pick_word());
        end
      end else if (pick < 7) begin
        counted += queue_op(deq_pkg::KIND_LIST, pick_word());
      end else begin
        // mixed traffic with the odd spare code as noise
        for (int i = 0; i < burst / 2; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            k = deq_pkg::KindW'($urandom_range(KindSpareLo, KindSpareHi));
          end else begin
            k = deq_pkg::KindW'($urandom_range(deq_pkg::KIND_PUSH_REAR, deq_pkg::KIND_LIST));
          end
          counted += queue_op(k, pick_word());
        end
      end
    end

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    wait (ops_accepted == ops_queued);
    wait (awaited_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
